// ===== src/reu_pkg.sv =====
// Shared types and constants for the integer execute unit.
package reu_pkg;

	localparam int REG_COUNT = 32;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int XLEN      = 32;

	localparam logic [XLEN-1:0] START_PC_RESET = 32'h0040_0000;
	localparam logic [XLEN-1:0] REGION_MASK    = 32'hF000_0000;
	localparam logic [REG_AW-1:0] LINK_REG     = 5'd31;

	typedef enum logic [5:0] {
		OP_ADD   = 6'd0,  OP_ADDU  = 6'd1,  OP_AND   = 6'd2,  OP_BREAK = 6'd3,
		OP_DIV   = 6'd4,  OP_MFHI  = 6'd5,  OP_MFLO  = 6'd6,  OP_MULT  = 6'd7,
		OP_OR    = 6'd8,  OP_NOP   = 6'd9,  OP_SLL   = 6'd10, OP_SEB   = 6'd11,
		OP_SLT   = 6'd12, OP_SLTU  = 6'd13, OP_SRL   = 6'd14, OP_SRA   = 6'd15,
		OP_SUB   = 6'd16, OP_SUBU  = 6'd17, OP_XOR   = 6'd18, OP_JALR  = 6'd19,
		OP_JR    = 6'd20, OP_ADDI  = 6'd21, OP_ADDIU = 6'd22, OP_ANDI  = 6'd23,
		OP_BGEZ  = 6'd24, OP_BEQ   = 6'd25, OP_BLEZ  = 6'd26, OP_BGTZ  = 6'd27,
		OP_BNE   = 6'd28, OP_BLTZ  = 6'd29, OP_LUI   = 6'd30, OP_ORI   = 6'd31,
		OP_SLTI  = 6'd32, OP_SLTIU = 6'd33, OP_J     = 6'd34, OP_JAL   = 6'd35
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVF   = 2'd1,
		ST_DIVZ  = 2'd2,
		ST_BREAK = 2'd3
	} status_t;

	// Divider control and result bundle.
	typedef struct packed {
		logic            start;
		logic [XLEN-1:0] dividend;
		logic [XLEN-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [XLEN-1:0] quotient;
		logic [XLEN-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== src/reu_regfile.sv =====
// General register file: two mirrored memories with registered reads and per-entry valid bits.
module reu_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [reu_pkg::REG_AW-1:0] rs_addr,
	input  logic [reu_pkg::REG_AW-1:0] rt_addr,
	input  logic                       wr_en,
	input  logic [reu_pkg::REG_AW-1:0] wr_addr,
	input  logic [reu_pkg::XLEN-1:0]   wr_data,
	output logic [reu_pkg::XLEN-1:0]   rs_data,
	output logic [reu_pkg::XLEN-1:0]   rt_data
);
	import reu_pkg::*;

	logic [XLEN-1:0]      mem_a [REG_COUNT];
	logic [XLEN-1:0]      mem_b [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [XLEN-1:0]      rs_q;
	logic [XLEN-1:0]      rt_q;

	// Write both copies
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered reads, register zero forced to zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rs_q <= (rs_addr != '0 && valid_q[rs_addr]) ? mem_a[rs_addr] : '0;
			rt_q <= (rt_addr != '0 && valid_q[rt_addr]) ? mem_b[rt_addr] : '0;
		end
	end

	assign rs_data = rs_q;
	assign rt_data = rt_q;

endmodule

// ===== src/reu_divider.sv =====
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module reu_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  reu_pkg::div_req_t req,
	output reu_pkg::div_rsp_t rsp
);
	import reu_pkg::*;

	localparam int CW = $clog2(XLEN + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   count_q;
	logic [XLEN-1:0] quo_q;
	logic [XLEN-1:0] rem_q;
	logic [XLEN-1:0] dvs_q;
	logic            neg_q_q;
	logic            neg_r_q;
	logic [XLEN:0]   trial;
	logic [XLEN:0]   shifted;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[XLEN-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= CW'(XLEN);
		end else if (busy_q) begin
			count_q <= count_q - 1'b1;
			if (count_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q   <= req.dividend[XLEN-1] ? -req.dividend : req.dividend;
			dvs_q   <= req.divisor[XLEN-1] ? -req.divisor : req.divisor;
			rem_q   <= '0;
			neg_q_q <= req.dividend[XLEN-1] ^ req.divisor[XLEN-1];
			neg_r_q <= req.dividend[XLEN-1];
		end else if (busy_q) begin
			if (!trial[XLEN]) begin
				rem_q <= trial[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= shifted[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = neg_q_q ? -quo_q : quo_q;
	assign rsp.remainder = neg_r_q ? -rem_q : rem_q;

endmodule

// ===== src/risc_integer_execute_unit_core.sv =====
// Top level of the integer execute unit: control, ALU, HI/LO, program counter.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_tvalid / s_tready     | s_tdata: decoded instruction
//  m_axis   | out | m_tvalid / m_tready     | m_tdata: next pc, status, write
//  cfg      | in  | cfg_valid / cfg_ready   | cfg_data: start pc
//
// Each instruction makes one register-file memory read, then executes and
// writes back. DIV then waits in a divide state for the iterative
// divider. Reset loads pc with the default start pc and a config transfer
// loads it at once; the register file needs no clearing pass. A stalled
// output holds the block in its execute or divide step.
module risc_integer_execute_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [5:0] opcode, [10:6] dest_index, [15:11] source_index, [20:16] target_index,
	// [25:21] shift_amount, [41:26] immediate, [67:42] jump_target, [71:68] zero
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] next_pc, [33:32] status, [34] write_enable, [39:35] write_index,
	// [71:40] write_value
	output logic [71:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import reu_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;

	state_t            state_q;
	logic [XLEN-1:0]   pc_q;
	logic [XLEN-1:0]   hi_q;
	logic [XLEN-1:0]   lo_q;
	logic              brk_q;
	logic [5:0]        op_s1;
	logic [REG_AW-1:0] rd_s1;
	logic [REG_AW-1:0] rt_s1;
	logic [4:0]        sa_s1;
	logic [15:0]       imm_s1;
	logic [25:0]       tgt_s1;
	logic              out_vld_q;
	logic [71:0]       out_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [XLEN-1:0]   a;
	logic [XLEN-1:0]   b;
	logic [XLEN-1:0]   link;
	logic [XLEN-1:0]   simm;
	logic [XLEN-1:0]   brt;
	logic [XLEN-1:0]   sum;
	logic [XLEN-1:0]   dif;
	logic [XLEN-1:0]   addi_sum;
	logic [2*XLEN-1:0] prod;
	logic [XLEN-1:0]   r_npc;
	status_t           r_status;
	logic              r_we;
	logic [REG_AW-1:0] r_widx;
	logic [XLEN-1:0]   r_wval;
	logic              r_mult;
	logic              r_div;
	logic              wb_en;
	div_req_t          dreq;
	div_rsp_t          drsp;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free  = !out_vld_q || m_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;

	reu_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rs_addr (s_tdata[15:11]),
		.rt_addr (s_tdata[20:16]),
		.wr_en   (wb_en),
		.wr_addr (r_widx),
		.wr_data (r_wval),
		.rs_data (a),
		.rt_data (b)
	);

	reu_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Execute one instruction from the registered operands
	always_comb begin
		link     = pc_q + 32'd4;
		simm     = {{16{imm_s1[15]}}, imm_s1};
		brt      = link + {simm[29:0], 2'b00};
		sum      = a + b;
		dif      = a - b;
		addi_sum = a + simm;
		prod     = $signed(a) * $signed(b);
		r_npc    = link;
		r_status = ST_OK;
		r_we     = 1'b0;
		r_widx   = rd_s1;
		r_wval   = '0;
		r_mult   = 1'b0;
		r_div    = 1'b0;
		case (op_s1)
			OP_ADD: begin
				if ((a[31] ^ sum[31]) & (b[31] ^ sum[31])) r_status = ST_OVF;
				else begin r_we = 1'b1; r_wval = sum; end
			end
			OP_ADDU:  begin r_we = 1'b1; r_wval = sum; end
			OP_AND:   begin r_we = 1'b1; r_wval = a & b; end
			OP_BREAK: r_status = ST_BREAK;
			OP_DIV: begin
				if (b == '0) r_status = ST_DIVZ;
				else r_div = 1'b1;
			end
			OP_MFHI:  begin r_we = 1'b1; r_wval = hi_q; end
			OP_MFLO:  begin r_we = 1'b1; r_wval = lo_q; end
			OP_MULT:  r_mult = 1'b1;
			OP_OR:    begin r_we = 1'b1; r_wval = a | b; end
			OP_SLL:   begin r_we = 1'b1; r_wval = b << sa_s1; end
			OP_SEB:   begin r_we = 1'b1; r_wval = {{24{b[7]}}, b[7:0]}; end
			OP_SLT:   begin r_we = 1'b1; r_wval = {31'd0, $signed(a) < $signed(b)}; end
			OP_SLTU:  begin r_we = 1'b1; r_wval = {31'd0, a < b}; end
			OP_SRL:   begin r_we = 1'b1; r_wval = b >> sa_s1; end
			OP_SRA:   begin r_we = 1'b1; r_wval = $unsigned($signed(b) >>> sa_s1); end
			OP_SUB: begin
				if ((a[31] ^ b[31]) & (a[31] ^ dif[31])) r_status = ST_OVF;
				else begin r_we = 1'b1; r_wval = dif; end
			end
			OP_SUBU:  begin r_we = 1'b1; r_wval = dif; end
			OP_XOR:   begin r_we = 1'b1; r_wval = a ^ b; end
			OP_JALR:  begin r_we = 1'b1; r_wval = link; r_npc = a; end
			OP_JR:    r_npc = a;
			OP_ADDI: begin
				r_widx = rt_s1;
				if ((a[31] ^ addi_sum[31]) & (simm[31] ^ addi_sum[31])) r_status = ST_OVF;
				else begin r_we = 1'b1; r_wval = addi_sum; end
			end
			OP_ADDIU: begin r_we = 1'b1; r_widx = rt_s1; r_wval = addi_sum; end
			OP_ANDI:  begin r_we = 1'b1; r_widx = rt_s1; r_wval = a & {16'd0, imm_s1}; end
			OP_BGEZ:  if (!a[31]) r_npc = brt;
			OP_BEQ:   if (a == b) r_npc = brt;
			OP_BLEZ:  if (a[31] || a == '0) r_npc = brt;
			OP_BGTZ:  if (!a[31] && a != '0) r_npc = brt;
			OP_BNE:   if (a != b) r_npc = brt;
			OP_BLTZ:  if (a[31]) r_npc = brt;
			OP_LUI:   begin r_we = 1'b1; r_widx = rt_s1; r_wval = {imm_s1, 16'd0}; end
			OP_ORI:   begin r_we = 1'b1; r_widx = rt_s1; r_wval = a | {16'd0, imm_s1}; end
			OP_SLTI: begin
				r_we = 1'b1; r_widx = rt_s1;
				r_wval = {31'd0, $signed(a) < $signed(simm)};
			end
			OP_SLTIU: begin r_we = 1'b1; r_widx = rt_s1; r_wval = {31'd0, a < simm}; end
			OP_J:     r_npc = (link & REGION_MASK) | {4'd0, tgt_s1, 2'b00};
			OP_JAL: begin
				r_npc  = (link & REGION_MASK) | {4'd0, tgt_s1, 2'b00};
				r_we   = 1'b1;
				r_widx = LINK_REG;
				r_wval = link;
			end
			default: ;
		endcase
		// Drop writes to register zero
		if (r_widx == '0) begin
			r_we   = 1'b0;
			r_wval = '0;
		end
		if (!r_we) r_widx = '0;
		// Halted: ignore everything
		if (brk_q) begin
			r_npc    = pc_q;
			r_status = ST_BREAK;
			r_we     = 1'b0;
			r_widx   = '0;
			r_wval   = '0;
			r_mult   = 1'b0;
			r_div    = 1'b0;
		end
	end

	assign wb_en = (state_q == S_EXEC) && out_free && r_we;

	// Load a new result into the output register
	assign out_load = ((state_q == S_EXEC) && !r_div && out_free) ||
		((state_q == S_DIV) && drsp.done && out_free);

	assign dreq.start    = (state_q == S_EXEC) && r_div;
	assign dreq.dividend = a;
	assign dreq.divisor  = b;

	// Sequence items and hold architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= START_PC_RESET;
			hi_q       <= '0;
			lo_q       <= '0;
			brk_q      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						pc_q <= cfg_data;
					end
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (r_div) begin
						state_q <= S_DIV;
					end else if (out_free) begin
						pc_q      <= r_npc;
						if (r_mult) begin
							hi_q <= prod[2*XLEN-1:XLEN];
							lo_q <= prod[XLEN-1:0];
						end
						if (r_status == ST_BREAK) brk_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (drsp.done && out_free) begin
						pc_q      <= link;
						hi_q      <= drsp.remainder;
						lo_q      <= drsp.quotient;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture instruction fields on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= s_tdata[5:0];
			rd_s1  <= s_tdata[10:6];
			rt_s1  <= s_tdata[20:16];
			sa_s1  <= s_tdata[25:21];
			imm_s1 <= s_tdata[41:26];
			tgt_s1 <= s_tdata[67:42];
		end
	end

	// Load output register
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && !r_div && out_free) begin
			out_q <= {r_wval, r_widx, r_we, r_status, r_npc};
		end else if (state_q == S_DIV && drsp.done && out_free) begin
			out_q <= {32'd0, 5'd0, 1'b0, ST_OK, link};
		end
	end

`ifndef SYNTHESIS
	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[39:35] != 5'd0)
		else $error("write to register zero reported");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_EXEC)
		else $error("accepted item not executed");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !drsp.busy)
		else $error("divider busy while idle");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q |=> brk_q)
		else $error("halt cleared without reset");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q && m_tvalid |-> m_tdata[33:32] == ST_BREAK)
		else $error("halted result without break status");
`endif

endmodule
